FILE: hw/rtl/sbid_pkg.sv
`default_nettype none
package sbid_pkg;

	localparam int OFFSET_WIDTH = 32;

	localparam logic [1:0] EV_INSTR   = 2'd0;
	localparam logic [1:0] EV_CAPTURE = 2'd1;
	localparam logic [1:0] EV_END     = 2'd2;
	localparam logic [1:0] EV_INVALID = 2'd3;

	localparam logic [1:0] PH_OPCODE  = 2'd0;
	localparam logic [1:0] PH_OPERAND = 2'd1;
	localparam logic [1:0] PH_KIND    = 2'd2;
	localparam logic [1:0] PH_INDEX   = 2'd3;

	localparam logic [1:0] NEED_BAD      = 2'd3;
	localparam logic [1:0] BYTE_CNT_LAST = 2'd3;
	localparam logic [1:0] KIND_MAX      = 2'd3;
	localparam logic [3:0] GRP_END       = 4'hF;
	localparam logic [7:0] OP_CLOSURE    = 8'h54;

	typedef struct packed {
		logic                    halted;
		logic [1:0]              phase;
		logic [7:0]              opcode_hold;
		logic [OFFSET_WIDTH-1:0] byte_offset;
		logic [OFFSET_WIDTH-1:0] start_offset;
		logic [1:0]              byte_cnt;
		logic [31:0]             acc;
		logic [31:0]             first_hold;
		logic [1:0]              operands_left;
		logic [31:0]             captures_left;
		logic [1:0]              kind_hold;
	} st_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] offset;
		logic [3:0]  group;
		logic [3:0]  variant;
		logic [1:0]  operand_count;
		logic [31:0] first_operand;
		logic [31:0] second_operand;
		logic [1:0]  capture_kind;
	} res_t;

	// Number of 32-bit operands after an opcode, NEED_BAD for undefined opcodes.
	function automatic logic [1:0] operand_need(input logic [3:0] g, input logic [3:0] v);
		logic [1:0] need;
		need = NEED_BAD;
		case (g)
			4'd0: begin
				if (v inside {[4'd1:4'd13]}) need = 2'd0;
			end
			4'd1: begin
				if (v inside {4'd0, 4'd1, 4'd5}) need = 2'd1;
				else if (v == 4'd2) need = 2'd2;
				else if (v inside {[4'd3:4'd11]}) need = 2'd0;
			end
			4'd2, 4'd3, 4'd4: begin
				if (v inside {[4'd0:4'd3]}) need = 2'd1;
			end
			4'd5: begin
				if (v inside {4'd0, 4'd1, 4'd5, 4'd8, 4'd10}) need = 2'd1;
				else if (v inside {[4'd0:4'd9]}) need = 2'd2;
			end
			4'd6: begin
				if (v inside {[4'd0:4'd6]}) need = 2'd0;
			end
			4'd7: begin
				if (v inside {[4'd0:4'd3]}) need = 2'd0;
				else if (v == 4'd4) need = 2'd1;
			end
			default: need = NEED_BAD;
		endcase
		return need;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sbid_decode.sv
`default_nettype none
module sbid_decode (
	input  wire sbid_pkg::st_t  st,
	input  wire logic [7:0]     code_byte,
	output sbid_pkg::st_t       st_next,
	output logic                res_valid,
	output sbid_pkg::res_t      res
);

	logic [1:0]  need;
	logic [31:0] acc_new;
	logic [31:0] here;
	logic [31:0] start;

	assign need    = sbid_pkg::operand_need(code_byte[7:4], code_byte[3:0]);
	assign acc_new = st.acc | (32'(code_byte) << {st.byte_cnt, 3'b000});
	assign here    = 32'(st.byte_offset);
	assign start   = 32'(st.start_offset);

	always_comb begin
		st_next   = st;
		res_valid = 1'b0;
		res       = '0;
		if (!st.halted) begin
			st_next.byte_offset = st.byte_offset + sbid_pkg::OFFSET_WIDTH'(1);
			case (st.phase)
				sbid_pkg::PH_OPCODE: begin
					st_next.opcode_hold  = code_byte;
					st_next.start_offset = st.byte_offset;
					res.offset  = here;
					res.group   = code_byte[7:4];
					res.variant = code_byte[3:0];
					if (code_byte[7:4] == sbid_pkg::GRP_END) begin
						res_valid      = 1'b1;
						res.event_res  = sbid_pkg::EV_END;
						st_next.halted = 1'b1;
					end else if (need == sbid_pkg::NEED_BAD) begin
						res_valid      = 1'b1;
						res.event_res  = sbid_pkg::EV_INVALID;
						st_next.halted = 1'b1;
					end else if (need == 2'd0) begin
						res_valid     = 1'b1;
						res.event_res = sbid_pkg::EV_INSTR;
					end else begin
						st_next.operands_left = need;
						st_next.byte_cnt      = '0;
						st_next.acc           = '0;
						st_next.phase         = sbid_pkg::PH_OPERAND;
					end
				end
				sbid_pkg::PH_KIND: begin
					if (code_byte > 8'(sbid_pkg::KIND_MAX)) begin
						res_valid      = 1'b1;
						res.event_res  = sbid_pkg::EV_INVALID;
						res.offset     = here;
						res.group      = st.opcode_hold[7:4];
						res.variant    = st.opcode_hold[3:0];
						st_next.halted = 1'b1;
					end else begin
						st_next.kind_hold    = code_byte[1:0];
						st_next.start_offset = st.byte_offset;
						st_next.byte_cnt     = '0;
						st_next.acc          = '0;
						st_next.phase        = sbid_pkg::PH_INDEX;
					end
				end
				default: begin
					// Operand or capture index bytes, least significant first.
					st_next.acc = acc_new;
					if (st.byte_cnt != sbid_pkg::BYTE_CNT_LAST) begin
						st_next.byte_cnt = st.byte_cnt + 2'd1;
					end else begin
						st_next.byte_cnt = '0;
						st_next.acc      = '0;
						res.offset       = start;
						res.group        = st.opcode_hold[7:4];
						res.variant      = st.opcode_hold[3:0];
						if (st.phase == sbid_pkg::PH_INDEX) begin
							res_valid                 = 1'b1;
							res.event_res             = sbid_pkg::EV_CAPTURE;
							res.operand_count         = 2'd1;
							res.first_operand         = acc_new;
							res.capture_kind          = st.kind_hold;
							st_next.captures_left     = st.captures_left - 32'd1;
							st_next.phase = (st.captures_left != 32'd1) ?
								sbid_pkg::PH_KIND : sbid_pkg::PH_OPCODE;
						end else if (st.operands_left == 2'd2) begin
							st_next.first_hold    = acc_new;
							st_next.operands_left = 2'd1;
						end else begin
							st_next.operands_left = '0;
							st_next.phase         = sbid_pkg::PH_OPCODE;
							res_valid             = 1'b1;
							res.event_res         = sbid_pkg::EV_INSTR;
							if (sbid_pkg::operand_need(st.opcode_hold[7:4],
								st.opcode_hold[3:0]) == 2'd2) begin
								res.operand_count  = 2'd2;
								res.first_operand  = st.first_hold;
								res.second_operand = acc_new;
							end else begin
								res.operand_count = 2'd1;
								res.first_operand = acc_new;
							end
							// A closure with a positive count is followed by its captures.
							if (st.opcode_hold == sbid_pkg::OP_CLOSURE) begin
								if (!acc_new[31] && acc_new != 32'd0) begin
									st_next.captures_left = acc_new;
									st_next.phase         = sbid_pkg::PH_KIND;
								end else begin
									st_next.captures_left = '0;
								end
							end
						end
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/stack_bytecode_instruction_decoder.sv
// Channel  Direction  Handshake                Payload
// input    in         in_valid / in_stall      code_byte
// output   out        out_valid / out_stall    event_res, offset, group, variant,
//                                              operand_count, first_operand,
//                                              second_operand, capture_kind
//
// One byte is accepted per cycle while in_stall is low; its result, if any, is shown on the next cycle
// unless the output register still holds an earlier request.
// The decode state is updated in the cycle a byte is accepted, by one pass of logic.
// A result register and one skid register hold results; in_stall rises only when
// both are full, and falls in the cycle after the output side takes a request.
// Reset clears the decode state and both result valid flags; after an end marker or
// an invalid opcode or capture kind, bytes are still accepted but ignored until the next reset.
`default_nettype none
module stack_bytecode_instruction_decoder (
	input  wire  logic               clk,
	input  wire  logic               arst_n,
	input  wire  logic               in_valid,
	output logic                     in_stall,
	input  wire  logic [7:0]         code_byte,
	output logic                     out_valid,
	input  wire  logic               out_stall,
	output logic [1:0]               event_res,
	output logic [31:0]              offset,
	output logic [3:0]               group,
	output logic [3:0]               variant,
	output logic [1:0]               operand_count,
	output logic signed [31:0]       first_operand,
	output logic signed [31:0]       second_operand,
	output logic [1:0]               capture_kind
);

	sbid_pkg::st_t  st_q;
	sbid_pkg::st_t  st_next;
	sbid_pkg::res_t res;
	sbid_pkg::res_t out_q;
	sbid_pkg::res_t skid_q;
	logic           res_valid;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           in_take;
	logic           out_take;
	logic           push;

	sbid_decode u_decode (
		.st        (st_q),
		.code_byte (code_byte),
		.st_next   (st_next),
		.res_valid (res_valid),
		.res       (res)
	);

	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign push     = in_take && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_take) begin
			st_q <= st_next;
		end
	end

	// A request is pushed only while the skid register is empty, so it always fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = out_q.event_res;
	assign offset         = out_q.offset;
	assign group          = out_q.group;
	assign variant        = out_q.variant;
	assign operand_count  = out_q.operand_count;
	assign first_operand  = out_q.first_operand;
	assign second_operand = out_q.second_operand;
	assign capture_kind   = out_q.capture_kind;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a request while the output register is empty");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |=> st_q.halted && $stable(st_q.byte_offset))
		else $error("decoder left the halted state or advanced its offset");

	a_kind_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == sbid_pkg::PH_KIND) |-> (st_q.captures_left != 32'd0))
		else $error("waiting for a capture kind with no captures left");

	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |-> !push)
		else $error("halted decoder produced a request");

endmodule
`default_nettype wire

FILE: bench/tb_stack_bytecode_instruction_decoder.sv
`timescale 1ns / 1ps
module tb_stack_bytecode_instruction_decoder;

	localparam int UNDEFINED_OP = -1;
	localparam int HOLD_CYCLES = 300;
	localparam int BYTES_PER_MIX = 375;
	localparam sbid_pkg::res_t NO_RES = '0;

	typedef enum logic [1:0] {NO_IDLE, SEND_GAPS, RECV_STALLS, BOTH_IDLE} idle_mode_t;

	typedef struct {
		logic [7:0]     code;
		bit             typed;
		sbid_pkg::res_t want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         code_byte = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         event_res;
	logic [31:0]        offset;
	logic [3:0]         group;
	logic [3:0]         variant;
	logic [1:0]         operand_count;
	logic signed [31:0] first_operand;
	logic signed [31:0] second_operand;
	logic [1:0]         capture_kind;

	// Decoder state as the bench expects it to be.
	logic [1:0]  dec_stage = sbid_pkg::PH_OPCODE;
	logic [7:0]  dec_op = '0;
	logic [sbid_pkg::OFFSET_WIDTH-1:0] dec_pos = '0;
	logic [31:0] dec_mark = '0;
	logic [1:0]  dec_nbytes = '0;
	logic [31:0] dec_acc = '0;
	logic [31:0] dec_first = '0;
	logic [1:0]  dec_words_left = '0;
	logic [31:0] dec_caps_left = '0;
	logic [1:0]  dec_kind = '0;
	bit          dec_halted = 1'b0;

	sbid_pkg::res_t decoded_q[$];
	idle_mode_t     idle_mode = NO_IDLE;
	bit             hold_req = 1'b0;
	int             hold_left = 0;
	int             bytes_sent = 0;
	int             results_seen = 0;
	int             caps_seen = 0;
	int             errors = 0;

	stack_bytecode_instruction_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.offset(offset),
		.group(group),
		.variant(variant),
		.operand_count(operand_count),
		.first_operand(first_operand),
		.second_operand(second_operand),
		.capture_kind(capture_kind)
	);

	always #5 clk = ~clk;

	// Number of 32-bit words that follow an opcode byte.
	function automatic int words_after(input logic [7:0] op);
		logic [3:0] g;
		logic [3:0] v;
		g = op[7:4];
		v = op[3:0];
		case (g)
			4'd0: return (v != 0 && v < 14) ? 0 : UNDEFINED_OP;
			4'd1: begin
				if (v == 2) return 2;
				if (v == 0 || v == 1 || v == 5) return 1;
				return (v < 12) ? 0 : UNDEFINED_OP;
			end
			4'd2, 4'd3, 4'd4: return (v < 4) ? 1 : UNDEFINED_OP;
			4'd5: begin
				if (v == 0 || v == 1 || v == 5 || v == 8 || v == 10) return 1;
				return (v < 10) ? 2 : UNDEFINED_OP;
			end
			4'd6: return (v < 7) ? 0 : UNDEFINED_OP;
			4'd7: begin
				if (v < 4) return 0;
				return (v == 4) ? 1 : UNDEFINED_OP;
			end
			default: return UNDEFINED_OP;
		endcase
	endfunction

	function automatic sbid_pkg::res_t pack_result(input logic [1:0] ev,
			input logic [31:0] off, input logic [7:0] op, input logic [1:0] cnt,
			input logic [31:0] a, input logic [31:0] b, input logic [1:0] kind);
		sbid_pkg::res_t r;
		r.event_res = ev;
		r.offset = off;
		r.group = op[7:4];
		r.variant = op[3:0];
		r.operand_count = cnt;
		r.first_operand = a;
		r.second_operand = b;
		r.capture_kind = kind;
		return r;
	endfunction

	function automatic string fmt_res(input sbid_pkg::res_t r);
		return $sformatf("ev=%0d off=%0d op=%h%h cnt=%0d a=%h b=%h kind=%0d", r.event_res,
			r.offset, r.group, r.variant, r.operand_count, r.first_operand,
			r.second_operand, r.capture_kind);
	endfunction

	// Advances the expected decode state by one byte; got is set when a result is due.
	task automatic decode_byte(input logic [7:0] b, output bit got,
			output sbid_pkg::res_t r);
		logic [31:0] here;
		int need;
		got = 1'b0;
		r = NO_RES;
		here = 32'(dec_pos);
		if (dec_halted) return;
		dec_pos = dec_pos + sbid_pkg::OFFSET_WIDTH'(1);
		case (dec_stage)
			sbid_pkg::PH_OPCODE: begin
				dec_op = b;
				dec_mark = here;
				need = words_after(b);
				if (b[7:4] == sbid_pkg::GRP_END) begin
					got = 1'b1;
					r = pack_result(sbid_pkg::EV_END, here, b, 2'd0, 0, 0, 2'd0);
					dec_halted = 1'b1;
				end else if (need == UNDEFINED_OP) begin
					got = 1'b1;
					r = pack_result(sbid_pkg::EV_INVALID, here, b, 2'd0, 0, 0, 2'd0);
					dec_halted = 1'b1;
				end else if (need == 0) begin
					got = 1'b1;
					r = pack_result(sbid_pkg::EV_INSTR, here, b, 2'd0, 0, 0, 2'd0);
				end else begin
					dec_words_left = 2'(need);
					dec_nbytes = '0;
					dec_acc = '0;
					dec_stage = sbid_pkg::PH_OPERAND;
				end
			end
			sbid_pkg::PH_KIND: begin
				if (b > 8'(sbid_pkg::KIND_MAX)) begin
					got = 1'b1;
					r = pack_result(sbid_pkg::EV_INVALID, here, dec_op, 2'd0, 0, 0, 2'd0);
					dec_halted = 1'b1;
				end else begin
					dec_kind = b[1:0];
					dec_mark = here;
					dec_nbytes = '0;
					dec_acc = '0;
					dec_stage = sbid_pkg::PH_INDEX;
				end
			end
			default: begin
				dec_acc = dec_acc | (32'(b) << (8 * dec_nbytes));
				if (dec_nbytes != sbid_pkg::BYTE_CNT_LAST) begin
					dec_nbytes = dec_nbytes + 2'd1;
				end else begin
					dec_nbytes = '0;
					if (dec_stage == sbid_pkg::PH_INDEX) begin
						got = 1'b1;
						r = pack_result(sbid_pkg::EV_CAPTURE, dec_mark, dec_op, 2'd1, dec_acc,
							0, dec_kind);
						dec_acc = '0;
						dec_caps_left = dec_caps_left - 32'd1;
						dec_stage = (dec_caps_left != 0) ? sbid_pkg::PH_KIND :
							sbid_pkg::PH_OPCODE;
					end else if (dec_words_left == 2) begin
						dec_first = dec_acc;
						dec_acc = '0;
						dec_words_left = 2'd1;
					end else begin
						dec_words_left = '0;
						got = 1'b1;
						dec_stage = sbid_pkg::PH_OPCODE;
						if (words_after(dec_op) == 2) begin
							r = pack_result(sbid_pkg::EV_INSTR, dec_mark, dec_op, 2'd2,
								dec_first, dec_acc, 2'd0);
						end else begin
							r = pack_result(sbid_pkg::EV_INSTR, dec_mark, dec_op, 2'd1,
								dec_acc, 0, 2'd0);
						end
						// A closure count that is zero or negative means no captures follow.
						if (dec_op == sbid_pkg::OP_CLOSURE && !dec_acc[31] && dec_acc != 0) begin
							dec_caps_left = dec_acc;
							dec_stage = sbid_pkg::PH_KIND;
						end else if (dec_op == sbid_pkg::OP_CLOSURE) begin
							dec_caps_left = '0;
						end
						dec_acc = '0;
					end
				end
			end
		endcase
	endtask

	function automatic bit idle_roll(input bit receiver);
		case (idle_mode)
			SEND_GAPS: return !receiver && $urandom_range(0, 99) < 76;
			RECV_STALLS: return receiver && $urandom_range(0, 99) < 76;
			BOTH_IDLE: return $urandom_range(0, 99) < 16;
			default: return 1'b0;
		endcase
	endfunction

	// Offers one byte and waits for it to be taken. Entered and left at a falling edge.
	task automatic send_byte(input logic [7:0] b, input bit typed,
			input sbid_pkg::res_t want);
		bit got;
		sbid_pkg::res_t r;
		while (idle_roll(1'b0)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		decode_byte(b, got, r);
		if (typed) decoded_q.push_back(want);
		else if (got) decoded_q.push_back(r);
		@(negedge clk);
	endtask

	task automatic send_word(input logic [31:0] w);
		int k;
		for (k = 0; k < 4; k++) send_byte(w[8*k +: 8], 1'b0, NO_RES);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_instruction();
		logic [7:0] op;
		logic [31:0] count;
		int k;
		if ($urandom_range(0, 7) == 0) begin
			op = sbid_pkg::OP_CLOSURE;
		end else begin
			op = 8'($urandom_range(0, 127));
			while (words_after(op) == UNDEFINED_OP) op = 8'($urandom_range(0, 127));
		end
		send_byte(op, 1'b0, NO_RES);
		if (op == sbid_pkg::OP_CLOSURE) begin
			send_word(rand_word());
			case ($urandom_range(0, 5))
				0: count = 32'd0;
				1: count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : (32'h8000_0000 | $urandom());
				default: count = $urandom_range(1, 3);
			endcase
			send_word(count);
			if (!count[31]) begin
				for (k = 0; k < count; k++) begin
					send_byte(8'($urandom_range(0, sbid_pkg::KIND_MAX)), 1'b0, NO_RES);
					send_word(rand_word());
				end
			end
		end else begin
			for (k = 0; k < words_after(op); k++) send_word(rand_word());
		end
	endtask

	// Receiver: random stalls, or one long hold-off so the decoder backs up into its input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_roll(1'b1);
		end
	end

	always @(posedge clk) begin
		sbid_pkg::res_t act;
		sbid_pkg::res_t want;
		if (out_valid && !out_stall) begin
			act = pack_result(event_res, offset, {group, variant}, operand_count, first_operand,
				second_operand, capture_kind);
			results_seen++;
			if (event_res == sbid_pkg::EV_CAPTURE) caps_seen++;
			if (decoded_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("%0t: unexpected result %s", $time, fmt_res(act));
			end else begin
				want = decoded_q.pop_front();
				if (act.event_res != want.event_res || act.offset != want.offset ||
						act.group != want.group || act.variant != want.variant ||
						act.operand_count != want.operand_count ||
						act.first_operand != want.first_operand ||
						act.second_operand != want.second_operand ||
						act.capture_kind != want.capture_kind) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
							fmt_res(want), fmt_res(act));
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		row_t script[$];
		string ending;
		logic [7:0] bad;
		int p;
		int target;
		script = '{
			'{8'h01, 1'b1, pack_result(sbid_pkg::EV_INSTR, 32'd0, 8'h01, 2'd0, 0, 0, 2'd0)},
			'{8'h12, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
			'{8'h00, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
			'{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
			'{8'hFF, 1'b1, pack_result(sbid_pkg::EV_INSTR, 32'd1, 8'h12, 2'd2, 32'h8000_0000,
				32'hFFFF_FFFF, 2'd0)},
			'{8'h54, 1'b0, NO_RES}, '{8'h7B, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
			'{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
			'{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
			'{8'h03, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
			'{8'hFF, 1'b0, NO_RES}, '{8'h7F, 1'b0, NO_RES},
			'{8'h0D, 1'b1, pack_result(sbid_pkg::EV_INSTR, 32'd24, 8'h0D, 2'd0, 0, 0, 2'd0)}
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) send_byte(script[i].code, script[i].typed, script[i].want);

		for (p = 0; p < 4; p++) begin
			idle_mode = idle_mode_t'(p);
			if (idle_mode == NO_IDLE) hold_req = 1'b1;
			target = bytes_sent + BYTES_PER_MIX;
			while (bytes_sent < target) send_instruction();
		end

		// Any halt is permanent until reset, so exactly one halting case closes the run.
		case ($urandom_range(0, 2))
			0: begin
				ending = "end marker";
				send_byte({sbid_pkg::GRP_END, 4'($urandom_range(0, 15))}, 1'b0, NO_RES);
			end
			1: begin
				ending = "undefined opcode";
				case ($urandom_range(0, 2))
					0: bad = 8'h00;
					1: bad = 8'h67 + 8'($urandom_range(0, 8));
					default: begin
						bad = 8'($urandom_range(0, 239));
						while (words_after(bad) != UNDEFINED_OP) bad = 8'($urandom_range(0, 239));
					end
				endcase
				send_byte(bad, 1'b0, NO_RES);
			end
			default: begin
				ending = "bad capture kind";
				send_byte(sbid_pkg::OP_CLOSURE, 1'b0, NO_RES);
				send_word(rand_word());
				send_word(32'd1);
				send_byte(8'($urandom_range(sbid_pkg::KIND_MAX + 1, 255)), 1'b0, NO_RES);
			end
		endcase
		repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);

		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		errors += decoded_q.size();
		$display("Checked %0d decoded results (%0d closure captures) from %0d bytes", results_seen,
			caps_seen, bytes_sent);
		$display("under four idling mixes and one long output hold-off; stream closed on a %s.",
			ending);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
